// ===== rtl/lfps_pkg.sv =====
// Shared constants, types and the helper function of the five-point Laplacian stencil unit.
package lfps_pkg;

  localparam int MAX_COLS     = 4096;
  localparam int MAX_ROWS     = 4096;
  localparam int SAMPLE_WIDTH = 32;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int LEN_W      = 13;
  localparam int INDEX_W    = 12;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIFF_W     = SAMPLE_WIDTH + 3;
  localparam int PROD_W     = DIFF_W + COEF_W + 1;
  localparam int SUM_W      = PROD_W + 1;
  localparam int RESULT_W   = 64;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int FLIGHT_W   = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_ROW_LENGTH = 2'd0;
  localparam cfg_index_t REG_ROW_COUNT  = 2'd1;
  localparam cfg_index_t REG_COEF_X     = 2'd2;
  localparam cfg_index_t REG_COEF_Y     = 2'd3;

  localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = LEN_W'(4096);
  localparam logic [LEN_W-1:0]  ROW_COUNT_RESET  = LEN_W'(4096);
  localparam logic [COEF_W-1:0] COEF_RESET       = COEF_W'(16777216);

  // Position and emit decision of one request, made when it is accepted.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] col_index;
  } tag_t;

  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] col_index;
    logic [INDEX_W-1:0] row_index;
    logic [RESULT_W-1:0] laplacian;
  } result_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] maxv);
    logic [LEN_W-1:0] r;
    if (v < LEN_W'(3)) begin
      r = LEN_W'(3);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/laplacian_five_point_stencil_unit.sv =====
// Five-point Laplacian stencil over a row-major sample stream.
// Each result passes the v1, v2 and v3 registers and the result queue on its way to m_axis.
// Throughput: one sample per clock while ready; each sample does one read-modify-write
// of the two line buffers, and an eight-entry result queue absorbs output stalls.
// Reset clears the position counters, the window and the registers to defaults;
// the line buffers are not cleared and hold data only once rows are written.
module laplacian_five_point_stencil_unit import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] sample
  input  logic                  s_axis_tuser,   // [0] frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [87:0]           m_axis_tdata,   // [63:0] laplacian, [75:64] row_index,
                                                // [87:76] col_index
  output logic                  m_axis_tlast,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]        row_length, row_count;
  logic [COEF_W-1:0]       coef_x, coef_y;
  logic                    accept, res_valid, pop;
  logic [COL_W-1:0]        col;
  tag_t                    tag;
  logic [SAMPLE_WIDTH-1:0] above, centre, right;
  logic [FLIGHT_W-1:0]     in_flight;
  logic [FIFO_CNT_W-1:0]   count;
  logic [FIFO_CNT_W:0]     committed;
  result_t                 res, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      row_count  <= ROW_COUNT_RESET;
      coef_x     <= COEF_RESET;
      coef_y     <= COEF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length <= cfg_data[LEN_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg_data[LEN_W-1:0];
        REG_COEF_X:     coef_x     <= cfg_data[COEF_W-1:0];
        REG_COEF_Y:     coef_y     <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Every request still in the pipeline has a queue slot reserved.
  assign committed     = (FIFO_CNT_W + 1)'(count) + (FIFO_CNT_W + 1)'(in_flight);
  assign s_axis_tready = committed < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  lfps_position u_position (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_axis_tuser),
    .row_length  (row_length),
    .row_count   (row_count),
    .col         (col),
    .tag         (tag)
  );

  lfps_line_buffers u_line_buffers (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .col    (col),
    .sample (s_axis_tdata),
    .above  (above),
    .centre (centre),
    .right  (right)
  );

  lfps_stencil_math u_math (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (s_axis_tdata),
    .tag       (tag),
    .above     (above),
    .centre    (centre),
    .right     (right),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .in_flight (in_flight),
    .res_valid (res_valid),
    .res       (res)
  );

  lfps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .count     (count)
  );

  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = {head.col_index, head.row_index, head.laplacian};
  assign m_axis_tlast  = head.last;

endmodule

// ===== rtl/lfps_position.sv =====
// Column and row counters of the streamed grid and the interior-point decision.
module lfps_position import lfps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             frame_start,
  input  logic [LEN_W-1:0] row_length,
  input  logic [LEN_W-1:0] row_count,
  output logic [COL_W-1:0] col,
  output tag_t             tag
);

  logic [COL_W-1:0] col_counter, col_counter_next;
  logic [ROW_W-1:0] row_counter, row_counter_next;
  logic [ROW_W-1:0] row;
  logic [LEN_W-1:0] len, rows, col_inc, row_inc, col_ext, row_ext;

  always_comb begin
    len     = clamp_len(row_length, LEN_W'(MAX_COLS));
    rows    = clamp_len(row_count, LEN_W'(MAX_ROWS));
    col     = frame_start ? '0 : col_counter;
    row     = frame_start ? '0 : row_counter;
    col_ext = LEN_W'(col);
    row_ext = LEN_W'(row);
    col_inc = col_ext + LEN_W'(1);
    row_inc = row_ext + LEN_W'(1);

    tag.emit      = (row_ext >= LEN_W'(2)) && (row_ext < rows) &&
                    (col_ext >= LEN_W'(1)) && (col_inc < len);
    tag.last      = (row_ext == rows - LEN_W'(1)) && (col_ext == len - LEN_W'(2));
    tag.row_index = INDEX_W'(row - ROW_W'(1));
    tag.col_index = INDEX_W'(col);

    // A column at or past the row end wraps to the next row.
    if (col_inc >= len) begin
      col_counter_next = '0;
      row_counter_next = (row_inc >= rows) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_counter_next = col_inc[COL_W-1:0];
      row_counter_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
    end else if (accept) begin
      col_counter <= col_counter_next;
      row_counter <= row_counter_next;
    end
  end

endmodule

// ===== rtl/lfps_line_buffers.sv =====
// Two row line buffers with registered reads and forwarding on the older row.
module lfps_line_buffers import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [COL_W-1:0]        col,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  output logic [SAMPLE_WIDTH-1:0] above,
  output logic [SAMPLE_WIDTH-1:0] centre,
  output logic [SAMPLE_WIDTH-1:0] right
);

  logic [SAMPLE_WIDTH-1:0] previous_row [MAX_COLS];
  logic [SAMPLE_WIDTH-1:0] older_row [MAX_COLS];

  logic [SAMPLE_WIDTH-1:0] prev_rd0, prev_rd1, older_rd, fwd_data;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_valid, fwd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Reads return the contents from before the write of the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd0          <= previous_row[col];
      prev_rd1          <= previous_row[col + COL_W'(1)];
      previous_row[col] <= sample;
      older_rd          <= older_row[col];
      s1_col            <= col;
      fwd_data          <= prev_rd0;
      fwd_hit           <= s1_valid && (col == s1_col);
    end
    // The older row takes the centre read in the cycle after its request.
    if (s1_valid) begin
      older_row[s1_col] <= prev_rd0;
    end
  end

  // The write from the previous request lands on the same edge as the
  // next read, so a matching address takes the forwarded value.
  assign above  = fwd_hit ? fwd_data : older_rd;
  assign centre = prev_rd0;
  assign right  = prev_rd1;

endmodule

// ===== rtl/lfps_stencil_math.sv =====
// Second differences, coefficient products and the saturating sum.
module lfps_stencil_math import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  tag_t                    tag,
  input  logic [SAMPLE_WIDTH-1:0] above,
  input  logic [SAMPLE_WIDTH-1:0] centre,
  input  logic [SAMPLE_WIDTH-1:0] right,
  input  logic [COEF_W-1:0]       coef_x,
  input  logic [COEF_W-1:0]       coef_y,
  output logic [FLIGHT_W-1:0]     in_flight,
  output logic                    res_valid,
  output result_t                 res
);

  logic                    v1, v2, v3;
  tag_t                    tag1, tag2, tag3;
  logic [SAMPLE_WIDTH-1:0] raw1, win0;
  logic signed [DIFF_W-1:0] dxx, dyy, dxx2, dyy2;
  logic signed [PROD_W-1:0] prod_x, prod_y, px3, py3;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-RESULT_W:0]  sum_top;

  always_comb begin
    dxx = $signed({{3{above[SAMPLE_WIDTH-1]}}, above})
        - $signed({{2{centre[SAMPLE_WIDTH-1]}}, centre, 1'b0})
        + $signed({{3{raw1[SAMPLE_WIDTH-1]}}, raw1});
    dyy = $signed({{3{win0[SAMPLE_WIDTH-1]}}, win0})
        - $signed({{2{centre[SAMPLE_WIDTH-1]}}, centre, 1'b0})
        + $signed({{3{right[SAMPLE_WIDTH-1]}}, right});
  end

  assign prod_x = dxx2 * $signed({1'b0, coef_x});
  assign prod_y = dyy2 * $signed({1'b0, coef_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      win0 <= '0;
    end else begin
      v1 <= accept;
      v2 <= v1 && tag1.emit;
      v3 <= v2;
      // The window shifts on every sample, emitting or not.
      if (v1) begin
        win0 <= centre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag1 <= tag;
      raw1 <= sample;
    end
    tag2 <= tag1;
    dxx2 <= dxx;
    dyy2 <= dyy;
    tag3 <= tag2;
    px3  <= prod_x;
    py3  <= prod_y;
  end

  always_comb begin
    sum     = {px3[PROD_W-1], px3} + {py3[PROD_W-1], py3};
    sum_top = sum[SUM_W-1:RESULT_W-1];
    res.last      = tag3.last;
    res.row_index = tag3.row_index;
    res.col_index = tag3.col_index;
    if ((sum_top == '0) || (sum_top == '1)) begin
      res.laplacian = sum[RESULT_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res.laplacian = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      res.laplacian = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  assign res_valid = v3;
  assign in_flight = FLIGHT_W'(v1) + FLIGHT_W'(v2) + FLIGHT_W'(v3);

endmodule

// ===== rtl/lfps_out_fifo.sv =====
// Small result queue in front of the output stream.
module lfps_out_fifo import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop,
  output result_t               head,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the five-point Laplacian stencil unit.
module testbench;
  import lfps_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  // Limit for a run of about five hundred requests, each one waiting on the slowest stall mix.
  localparam int CYCLE_LIMIT = 20_000;
  localparam logic signed [127:0] LAP_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] LAP_MIN = -LAP_MAX - 128'sd1;

  typedef struct {
    logic [31:0] sample;
    logic        frame_start;
  } grid_sample_t;

  typedef struct {
    logic [63:0]        laplacian;
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] col_index;
    logic               last;
  } stencil_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [87:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_write = 1'b0;
  cfg_index_t            cfg_index = REG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_sample_t sample_feed_q[$];
  stencil_out_t laplacian_q[$];

  // Mirror of the block's registers and line buffers.
  logic [LEN_W-1:0] len_reg;
  logic [LEN_W-1:0] rows_reg;
  logic [31:0]      coef_x;
  logic [31:0]      coef_y;
  logic [31:0]      older_buf[MAX_COLS];
  logic [31:0]      newer_buf[MAX_COLS];
  logic [31:0]      left_tap;
  int unsigned      col_pos;
  int unsigned      row_pos;

  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [9:0]  sink_cycle = '0;
  int          rand_items;
  int          grids;

  laplacian_five_point_stencil_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v, input int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(0, 2048)) - 32'd1024;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h0100_0000;
      4: return 32'($urandom_range(0, 1024));
      default: return $urandom;
    endcase
  endfunction

  // Works out the result, if any, of one accepted sample and advances the mirror.
  task automatic apply_stencil_sample(input logic [31:0] smp, input logic fs);
    int unsigned len, rows, c, r;
    logic [31:0] above, centre, right;
    longint dxx, dyy;
    logic signed [127:0] wx, wy, tot;
    stencil_out_t res;
    len = eff_len(len_reg, MAX_COLS);
    rows = eff_len(rows_reg, MAX_ROWS);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    above = older_buf[c];
    centre = newer_buf[c];
    right = (c + 1 < MAX_COLS) ? newer_buf[c + 1] : '0;
    if (r >= 2 && r < rows && c >= 1 && c + 1 < len) begin
      dxx = longint'($signed(above)) - 2 * longint'($signed(centre)) + longint'($signed(smp));
      dyy = longint'($signed(left_tap)) - 2 * longint'($signed(centre))
          + longint'($signed(right));
      wx = dxx;
      wy = dyy;
      tot = wx * $signed({96'd0, coef_x}) + wy * $signed({96'd0, coef_y});
      if (tot > LAP_MAX) begin
        res.laplacian = LAP_MAX[63:0];
      end else if (tot < LAP_MIN) begin
        res.laplacian = LAP_MIN[63:0];
      end else begin
        res.laplacian = tot[63:0];
      end
      res.row_index = INDEX_W'(r - 1);
      res.col_index = INDEX_W'(c);
      res.last = (r == rows - 1 && c == len - 2);
      laplacian_q.push_back(res);
    end
    if (c < MAX_COLS) begin
      older_buf[c] = centre;
      newer_buf[c] = smp;
    end
    left_tap = centre;
    if (c + 1 >= len) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    stencil_out_t want;
    if (laplacian_q.size() == 0) begin
      err_count++;
      if (err_count <= 10) begin
        $display("cycle %0d: result with none expected: laplacian %h row %0d col %0d last %b",
                 cycle_count, m_axis_tdata[63:0], m_axis_tdata[75:64], m_axis_tdata[87:76],
                 m_axis_tlast);
      end
    end else begin
      want = laplacian_q.pop_front();
      if (m_axis_tdata[63:0] !== want.laplacian || m_axis_tdata[75:64] !== want.row_index ||
          m_axis_tdata[87:76] !== want.col_index || m_axis_tlast !== want.last) begin
        err_count++;
        if (err_count <= 10) begin
          $display("cycle %0d: mismatch (expected/actual) laplacian %h/%h row %0d/%0d",
                   cycle_count, want.laplacian, m_axis_tdata[63:0], want.row_index,
                   m_axis_tdata[75:64]);
          $display("  col %0d/%0d last %b/%b", want.col_index, m_axis_tdata[87:76],
                   want.last, m_axis_tlast);
        end
      end
    end
  endtask

  // Register mirror, prediction of accepted requests and checking of results.
  always @(posedge clk) begin
    if (rst) begin
      len_reg = ROW_LENGTH_RESET;
      rows_reg = ROW_COUNT_RESET;
      coef_x = COEF_RESET;
      coef_y = COEF_RESET;
      left_tap = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          REG_ROW_COUNT:  rows_reg = cfg_data[LEN_W-1:0];
          REG_COEF_X:     coef_x = cfg_data;
          REG_COEF_Y:     coef_y = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_stencil_sample(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
    end
  end

  // Sender: bursts of random length separated by random gaps, sometimes none.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_feed_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample_feed_q[0].sample;
        s_axis_tuser <= sample_feed_q[0].frame_start;
        void'(sample_feed_q.pop_front());
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Receiver: cycles through always ready, mostly ready, mostly stalled and on/off stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      sink_cycle <= sink_cycle + 10'd1;
      case (sink_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= sink_cycle[3];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_sample(input logic [31:0] v, input logic fs);
    grid_sample_t req;
    req.sample = v;
    req.frame_start = fs;
    sample_feed_q.push_back(req);
  endtask

  // Idle means every request taken, every result seen, and the pipeline drained.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_feed_q.size() != 0 || s_axis_tvalid || laplacian_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic program_grid(input logic [31:0] len_data, input logic [31:0] rows_data,
                              input logic [31:0] kx, input logic [31:0] ky);
    write_reg(REG_ROW_LENGTH, len_data);
    write_reg(REG_ROW_COUNT, rows_data);
    write_reg(REG_COEF_X, kx);
    write_reg(REG_COEF_Y, ky);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Queues n samples grid after grid; the noisy form adds restarts and overruns.
  task automatic run_grids(input logic [31:0] len_data, input logic [31:0] rows_data,
                           input int n, input bit noisy);
    int unsigned span, pos;
    bit fs;
    span = eff_len(len_data[LEN_W-1:0], MAX_COLS) * eff_len(rows_data[LEN_W-1:0], MAX_ROWS);
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        fs = 1'b1;
      end else if (pos == 0) begin
        fs = !noisy || ($urandom_range(0, 3) != 0);
      end else begin
        fs = noisy && ($urandom_range(0, 59) == 0);
      end
      if (fs) pos = 0;
      push_sample(pick_sample(), fs);
      pos = (pos + 1) % span;
    end
  endtask

  function automatic logic [31:0] pick_len(input int unsigned hi);
    logic [31:0] v;
    v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, hi);
    if ($urandom_range(0, 1) == 0) v = v | ($urandom & 32'hFFFF_E000);
    return v;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Smallest grid, lengths below range (upper data bits set), coefficients at reset.
    write_reg(REG_ROW_LENGTH, 32'hFFFF_E000);
    write_reg(REG_ROW_COUNT, 32'd2);
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int i = 0; i < 9; i++) push_sample(32'(i) * 32'h0F1E_2D3C, i == 0);
    // A second grid without frame start: the position wraps on its own.
    for (int i = 0; i < 9; i++) push_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
    wait_idle();

    // Extreme checkerboards with full-scale weights saturate both ways.
    program_grid(32'd4, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      push_sample((((i / 4) + (i % 4)) % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000, i == 0);
    end
    for (int i = 0; i < 12; i++) begin
      push_sample((((i / 4) + (i % 4)) % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 0);
    end
    wait_idle();

    // Frame start in the middle of a grid restarts the position.
    program_grid(32'd5, 32'd4, 32'd0, 32'd1);
    for (int i = 0; i < 27; i++) push_sample(pick_sample(), i == 0 || i == 7);
    wait_idle();

    // Lengths shrink while the position sits past the new row end.
    program_grid(32'd8, 32'd6, pick_coef(), pick_coef());
    for (int i = 0; i < 30; i++) push_sample(pick_sample(), i == 0);
    wait_idle();
    program_grid(32'd5, 32'd4, pick_coef(), pick_coef());
    for (int i = 0; i < 21; i++) push_sample(pick_sample(), 1'b0);
    wait_idle();

    // Widest rows (clamped from above): the first row must not wrap early.
    program_grid(32'hFFFF_FFFF, 32'd3, pick_coef(), pick_coef());
    run_grids(32'hFFFF_FFFF, 32'd3, 30, 1'b0);
    wait_idle();
    // Tallest grid (clamped from above): rows keep counting past a small wrap.
    program_grid(32'd3, 32'd8191, pick_coef(), pick_coef());
    run_grids(32'd3, 32'd8191, 60, 1'b0);
    wait_idle();

    rand_items = 0;
    while (rand_items < 220) begin
      logic [31:0] len_data, rows_data;
      len_data = pick_len(12);
      rows_data = pick_len(8);
      grids = $urandom_range(1, 3);
      program_grid(len_data, rows_data, pick_coef(), pick_coef());
      run_grids(len_data, rows_data, grids * eff_len(len_data[LEN_W-1:0], MAX_COLS)
                * eff_len(rows_data[LEN_W-1:0], MAX_ROWS), 1'b1);
      rand_items += grids * eff_len(len_data[LEN_W-1:0], MAX_COLS)
                  * eff_len(rows_data[LEN_W-1:0], MAX_ROWS);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
